>>> src/pcshp_pkg.sv
// Shared types and constants for the pc sample hotspot profiler.
// No dependencies; every other file of the block imports this package.
package pcshp_pkg;

   localparam int ENTRIES     = 4096;
   localparam int TOP_N       = 20;
   localparam int MAX_RESULTS = 64;
   localparam int RUNS        = (TOP_N > MAX_RESULTS) ? MAX_RESULTS : TOP_N;

   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int CNT_W   = IDX_W + 1;
   localparam int RUN_W   = $clog2(RUNS + 1);
   localparam int WIN_W   = 13;
   localparam int CSR_W   = 4;

   localparam logic [31:0] RESET_BASE   = 32'h0000_8000;
   localparam logic [WIN_W-1:0] RESET_WINDOW = 13'd4096;

   // request codes
   localparam logic [1:0] REQ_SAMPLE = 2'd0;
   localparam logic [1:0] REQ_CLEAR  = 2'd1;
   localparam logic [1:0] REQ_REPORT = 2'd2;

   // register indexes
   localparam logic [CSR_W-1:0] CSR_BASE   = 4'd0;
   localparam logic [CSR_W-1:0] CSR_WINDOW = 4'd1;

   typedef enum logic [1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_CLEAR  = 2'd1,
      CMD_REPORT = 2'd2
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type       op;
      logic [IDX_W-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic [31:0]      base;
      logic [CNT_W-1:0] span;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] sample_pc;
   } req_item_type;

   typedef struct packed {
      logic [31:0] hit_count;
      logic [11:0] word_index;
      logic [31:0] hit_address;
      logic        last;
   } rsp_item_type;

endpackage

>>> src/pcshp_front.sv
// Front end: configuration registers, request classification and queue push.
// Depends on pcshp_pkg.
module pcshp_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [pcshp_pkg::CSR_W-1:0] csr_index,
   input  logic [31:0]                csr_wdata,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  pcshp_pkg::req_item_type    req_data,
   input  logic                       q_ready,
   input  logic                       init_busy,
   output logic                       push_valid,
   output pcshp_pkg::cmd_type         push_cmd,
   output pcshp_pkg::cfg_type         cfg
);
   import pcshp_pkg::*;

   logic [31:0]      base_ff,   base_in;
   logic [WIN_W-1:0] window_ff, window_in;
   logic [31:0]      win32;
   logic [CNT_W-1:0] span;
   logic [31:0]      offset;
   logic             aligned;
   logic             in_win;
   logic             keep;

   assign csr_ready = 1'b1;

   always_comb begin
      base_in   = base_ff;
      window_in = window_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_BASE:   base_in   = csr_wdata;
            CSR_WINDOW: window_in = csr_wdata[WIN_W-1:0];
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= RESET_BASE;
         window_ff <= RESET_WINDOW;
      end else begin
         base_ff   <= base_in;
         window_ff <= window_in;
      end
   end

   // clamp the window to the table depth
   assign win32 = 32'(window_ff);
   assign span  = (win32 > 32'(ENTRIES)) ? CNT_W'(ENTRIES) : CNT_W'(win32);

   assign cfg.base = base_ff;
   assign cfg.span = span;

   assign offset  = req_data.sample_pc - base_ff;
   assign aligned = (offset[1:0] == 2'b00);
   assign in_win  = (32'(span) > {2'b00, offset[31:2]});

   always_comb begin
      keep        = 1'b0;
      push_cmd.op = CMD_SAMPLE;
      push_cmd.idx = offset[IDX_W+1:2];
      case (req_data.req_type)
         REQ_SAMPLE: keep = aligned && in_win;
         REQ_CLEAR: begin
            keep        = 1'b1;
            push_cmd.op = CMD_CLEAR;
         end
         REQ_REPORT: begin
            keep        = 1'b1;
            push_cmd.op = CMD_REPORT;
         end
         default: keep = 1'b0;
      endcase
   end

   // drop ignored requests here; they never reach the queue
   assign req_ready  = q_ready && !init_busy;
   assign push_valid = req_valid && req_ready && keep;

endmodule

>>> src/pcshp_queue.sv
// Two-entry command queue between the front end and the bin engine.
// Depends on pcshp_pkg.
module pcshp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  pcshp_pkg::cmd_type push_cmd,
   output logic               q_ready,
   output logic               pop_valid,
   output pcshp_pkg::cmd_type pop_cmd,
   input  logic               pop
);
   import pcshp_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;
   logic       do_push, do_pop;

   assign q_ready   = (count_ff != 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_cmd   = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid && q_ready;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 2'd1;
      if (do_pop && !do_push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

>>> src/pcshp_back.sv
// Bin engine: histogram memory, clear sweep, sample update and top-N scan.
// Depends on pcshp_pkg.
module pcshp_back (
   input  logic                    clock,
   input  logic                    reset,
   input  pcshp_pkg::cfg_type      cfg,
   input  logic                    cmd_valid,
   input  pcshp_pkg::cmd_type      cmd,
   output logic                    pop,
   output logic                    init_busy,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output pcshp_pkg::rsp_item_type rsp_data
);
   import pcshp_pkg::*;

   typedef enum logic [5:0] {
      ST_INIT  = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_RMW   = 6'b000100,
      ST_CLEAR = 6'b001000,
      ST_SCAN  = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   logic [31:0]      mem [ENTRIES];
   logic [31:0]      rd_data_ff;
   logic [IDX_W-1:0] mem_raddr, mem_waddr;
   logic [31:0]      mem_wdata;
   logic             mem_we;

   logic [IDX_W-1:0] clr_ff,       clr_in;
   logic [IDX_W-1:0] upd_idx_ff,   upd_idx_in;
   logic [CNT_W-1:0] scan_addr_ff, scan_addr_in;
   logic             rd_valid_ff,  rd_valid_in;
   logic [IDX_W-1:0] rd_idx_ff,    rd_idx_in;
   logic [31:0]      best_ff,      best_in;
   logic [IDX_W-1:0] where_ff,     where_in;
   logic [RUN_W-1:0] run_ff,       run_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_data_ff,  rsp_data_in;

   logic             issue;
   logic             out_load;
   logic [31:0]      where32;

   assign init_busy = (state_ff == ST_INIT);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign issue     = (scan_addr_ff < cfg.span);
   assign out_load  = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign where32   = 32'(where_ff);
   assign pop       = (state_ff == ST_IDLE) && cmd_valid;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      upd_idx_in   = upd_idx_ff;
      scan_addr_in = scan_addr_ff;
      rd_valid_in  = 1'b0;
      rd_idx_in    = scan_addr_ff[IDX_W-1:0];
      best_in      = best_ff;
      where_in     = where_ff;
      run_in       = run_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mem_raddr    = cmd.idx;
      mem_we       = 1'b0;
      mem_waddr    = clr_ff;
      mem_wdata    = 32'd0;

      case (state_ff)
         ST_INIT, ST_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.op)
                  CMD_SAMPLE: begin
                     upd_idx_in = cmd.idx;
                     state_in   = ST_RMW;
                  end
                  CMD_CLEAR: begin
                     clr_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  CMD_REPORT: begin
                     run_in       = '0;
                     scan_addr_in = '0;
                     best_in      = 32'd0;
                     where_in     = '0;
                     state_in     = ST_SCAN;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_RMW: begin
            // saturate at all ones
            mem_we    = 1'b1;
            mem_waddr = upd_idx_ff;
            mem_wdata = (rd_data_ff == 32'hFFFF_FFFF) ? rd_data_ff : rd_data_ff + 32'd1;
            state_in  = ST_IDLE;
         end
         ST_SCAN: begin
            mem_raddr = scan_addr_ff[IDX_W-1:0];
            if (issue) begin
               rd_valid_in  = 1'b1;
               scan_addr_in = scan_addr_ff + CNT_W'(1);
            end
            // strict compare keeps the lowest index on ties
            if (rd_valid_ff && (rd_data_ff > best_ff)) begin
               best_in  = rd_data_ff;
               where_in = rd_idx_ff;
            end
            if (!issue && !rd_valid_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_load) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.hit_count   = best_ff;
               rsp_data_in.word_index  = where32[11:0];
               rsp_data_in.hit_address = cfg.base + {where32[29:0], 2'b00};
               rsp_data_in.last        = (run_ff == RUN_W'(RUNS - 1));
               mem_we                  = (best_ff != 32'd0);
               mem_waddr               = where_ff;
               if (run_ff == RUN_W'(RUNS - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  run_in       = run_ff + RUN_W'(1);
                  scan_addr_in = '0;
                  best_in      = 32'd0;
                  where_in     = '0;
                  state_in     = ST_SCAN;
               end
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         clr_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      upd_idx_ff   <= upd_idx_in;
      scan_addr_ff <= scan_addr_in;
      rd_idx_ff    <= rd_idx_in;
      best_ff      <= best_in;
      where_ff     <= where_in;
      run_ff       <= run_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= mem[mem_raddr];
   end

   a_sample_to_rmw: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && cmd_valid && cmd.op == CMD_SAMPLE) |=> (state_ff == ST_RMW))
      else $error("sample pop not followed by bin update");

   a_rmw_no_wrap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RMW) |-> (mem_wdata >= rd_data_ff))
      else $error("bin counter wrapped");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (out_load && rsp_data_in.last) |=> (state_ff == ST_IDLE))
      else $error("report kept running after final result");

   a_read_from_scan: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> $past(state_ff == ST_SCAN))
      else $error("scan data outside a scan");

endmodule

>>> src/pc_sample_hotspot_profiler.sv
// Top level of the pc sample hotspot profiler: front end, command queue, bin engine.
// Depends on pcshp_pkg, pcshp_front, pcshp_queue and pcshp_back.
//
//   channel   direction  handshake               payload
//   req_      in         req_valid / req_ready   req_item_type (req_type, sample_pc)
//   rsp_      out        rsp_valid / rsp_ready   rsp_item_type (count, index, address, last)
//   csr_      in         csr_valid / csr_ready   csr_index, csr_wdata
//
// After reset the engine sweeps the whole bin table with req_ready low.
// A sample is a memory read, then a saturating write back.
// A clear sweeps the whole table; a report takes TOP_N runs (window reads, read latency,
// final compare, emit), each run walking the window once through the single memory read
// port. The queue lets the front keep accepting while a queue slot is free and the engine
// works; a stalled rsp_ready holds the engine in its emit step.
module pc_sample_hotspot_profiler (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  pcshp_pkg::req_item_type     req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output pcshp_pkg::rsp_item_type     rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [pcshp_pkg::CSR_W-1:0] csr_index,
   input  logic [31:0]                 csr_wdata
);
   import pcshp_pkg::*;

   logic    q_ready;
   logic    init_busy;
   logic    push_valid;
   cmd_type push_cmd;
   logic    pop_valid;
   cmd_type pop_cmd;
   logic    pop;
   cfg_type cfg;

   // classify and drop ignored requests before they take a queue slot
   pcshp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .q_ready    (q_ready),
      .init_busy  (init_busy),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .cfg        (cfg)
   );

   // hold commands while the engine is busy
   pcshp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .q_ready    (q_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop        (pop)
   );

   // advance commands through the bin memory and drive the result register
   pcshp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_valid (pop_valid),
      .cmd       (pop_cmd),
      .pop       (pop),
      .init_busy (init_busy),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
